// ===== rtl/core/sidec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sidec_pkg;

  localparam int MagW          = 32;
  localparam int DigitsN       = 10;
  localparam int BcdW          = 4 * DigitsN;
  localparam int StagesN       = 4;
  localparam int StepsPerStage = MagW / StagesN;
  localparam int DigitIdxW     = $clog2(DigitsN);

  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharNine  = 7'h39;
  localparam logic [6:0] CharMinus = 7'h2D;

  // Word carried down the conversion pipeline: the binary bits still to be
  // shifted in, the decimal digits built so far and the sign.
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] bin;
    logic [BcdW-1:0] bcd;
  } sidec_word_t;

  // Handshake between two neighbouring pipeline stages.
  typedef struct packed {
    logic valid;
    logic ready;
  } sidec_hs_t;

  // One stage's share of the shift-and-add-three conversion.
  function automatic sidec_word_t dabble_steps(sidec_word_t w);
    sidec_word_t r;
    r = w;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < DigitsN; d++) begin
        if (r.bcd[d*4 +: 4] >= 4'd5) begin
          r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd[BcdW-2:0], r.bin, 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sidec_dabble_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sidec_dabble_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  sidec_pkg::sidec_word_t word_i,
  output sidec_pkg::sidec_hs_t   hs_o,
  input  logic                   ready_i,
  output sidec_pkg::sidec_word_t word_o
);
  import sidec_pkg::*;

  logic        valid_q;
  logic        ready;
  sidec_word_t word_d, word_q;

  // The stage may take a beat when it is empty or its beat moves on now.
  assign ready  = !valid_q || ready_i;
  assign word_d = dabble_steps(word_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && valid_i) begin
      word_q <= word_d;
    end
  end

  assign hs_o.valid = valid_q;
  assign hs_o.ready = ready;
  assign word_o     = word_q;

endmodule

`default_nettype wire

// ===== rtl/core/sidec_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sidec_serializer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  sidec_pkg::sidec_word_t word_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output logic [6:0]             character_o,
  output logic                   last_o
);
  import sidec_pkg::*;

  logic                 active_q, active_d;
  logic                 sign_q, sign_d;
  logic [DigitIdxW-1:0] idx_q, idx_d;
  logic [BcdW-1:0]      bcd_q;
  logic [DigitIdxW-1:0] top_idx;
  logic                 final_beat;
  logic                 load;

  // Position of the leading non-zero digit; zero itself prints one digit.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < DigitsN; d++) begin
      if (word_i.bcd[d*4 +: 4] != 4'd0) begin
        top_idx = DigitIdxW'(d);
      end
    end
  end

  assign final_beat = active_q && !sign_q && (idx_q == '0);
  assign ready_o    = !active_q || final_beat;
  assign load       = ready_o && valid_i;

  always_comb begin
    active_d = active_q;
    sign_d   = sign_q;
    idx_d    = idx_q;
    if (load) begin
      active_d = 1'b1;
      sign_d   = word_i.neg;
      idx_d    = top_idx;
    end else if (final_beat) begin
      active_d = 1'b0;
    end else if (active_q) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else begin
        idx_d = idx_q - DigitIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      sign_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      active_q <= active_d;
      sign_q   <= sign_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q <= word_i.bcd;
    end
  end

  assign valid_o     = active_q;
  assign character_o = sign_q ? CharMinus : (CharZero + {3'b000, bcd_q[idx_q*4 +: 4]});
  assign last_o      = !sign_q && (idx_q == '0);

endmodule

`default_nettype wire

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed 32-bit integer into its decimal ASCII text, most
// significant character first, with a leading '-' for negative values, no
// leading zeros, and last_o set on the final character. A value is taken on
// a clock edge with start high and busy low. It passes an input register
// that forms the magnitude and four conversion stages of eight shift steps
// each, then the register of the output stage, before its first character
// appears. The output stage then sends one character per cycle on valid_o,
// and the receiver must take every beat as it comes. A value has one to
// eleven characters, and the output stage sets the sustained rate; while it
// is busy the pipeline behind it keeps accepting until its five stages are
// full, and busy then rises.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  output logic        valid_o,
  output logic [6:0]  character_o,
  output logic        last_o
);
  import sidec_pkg::*;

  logic        in_valid_q;
  logic        in_ready;
  sidec_word_t in_word_d, in_word_q;
  logic [MagW-1:0] mag;

  logic        stage_valid [StagesN+1];
  logic        stage_ready [StagesN+1];
  sidec_word_t stage_word  [StagesN+1];
  sidec_hs_t   stage_hs    [StagesN];

  // Two's-complement negation in the unsigned domain keeps the most
  // negative value exact.
  assign mag             = value_i[MagW-1] ? (~value_i + MagW'(1)) : value_i;
  assign in_word_d.neg   = value_i[MagW-1];
  assign in_word_d.bin   = mag;
  assign in_word_d.bcd   = '0;

  assign in_ready = !in_valid_q || stage_ready[0];
  assign busy     = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && start) begin
      in_word_q <= in_word_d;
    end
  end

  assign stage_valid[0] = in_valid_q;
  assign stage_word[0]  = in_word_q;

  for (genvar k = 0; k < StagesN; k++) begin : g_stage
    sidec_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .word_i  (stage_word[k]),
      .hs_o    (stage_hs[k]),
      .ready_i (stage_ready[k+1]),
      .word_o  (stage_word[k+1])
    );
    assign stage_ready[k]   = stage_hs[k].ready;
    assign stage_valid[k+1] = stage_hs[k].valid;
  end

  sidec_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid[StagesN]),
    .word_i      (stage_word[StagesN]),
    .ready_o     (stage_ready[StagesN]),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // Every character sent is a minus sign or a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (character_o == CharMinus) ||
                ((character_o >= CharZero) && (character_o <= CharNine)))
    else $error("character out of range");

  // A minus sign never ends a number and is followed at once by a digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && character_o == CharMinus) |-> !last_o)
    else $error("minus sign flagged as last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && character_o == CharMinus) |=> (valid_o && character_o != CharMinus))
    else $error("minus sign not followed by a digit");

  // An accepted value is held in the input register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> in_valid_q)
    else $error("accepted value lost");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sidec_pkg::*;

  localparam int RandomValues = 410;
  localparam int StallLimit   = 1000;
  localparam int DrainCycles  = 24;
  localparam int MaxGap       = 12;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } text_beat_t;

  typedef struct {
    logic [31:0] value;
    string       text;
  } directed_row_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  logic [31:0] value_i = '0;
  logic        valid_o;
  logic [6:0]  character_o;
  logic        last_o;

  text_beat_t text_due[$];
  int         errors         = 0;
  int         values_sent    = 0;
  int         negatives_sent = 0;
  int         longest_texts  = 0;
  int         beats_seen     = 0;
  int         idle_cycles    = 0;

  // An empty text leaves the expectation to the predictor.
  directed_row_t directed[19] = '{
    '{32'd0,               "0"},
    '{32'd1,               "1"},
    '{-32'sd1,             "-1"},
    '{32'd9,               "9"},
    '{32'd10,              "10"},
    '{-32'sd10,            "-10"},
    '{32'd100,             "100"},
    '{-32'sd99,            "-99"},
    '{32'd2147483647,      "2147483647"},
    '{32'h8000_0000,       "-2147483648"},
    '{32'h8000_0001,       "-2147483647"},
    '{32'd999999999,       "999999999"},
    '{32'd1000000000,      "1000000000"},
    '{-32'sd1000000000,    "-1000000000"},
    '{32'd12345,           ""},
    '{32'h5555_5555,       ""},
    '{32'hAAAA_AAAA,       ""},
    '{32'h7FFF_FFFE,       ""},
    '{32'h0000_FFFF,       ""}
  };

  signed_int_to_decimal_ascii u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Decimal text of a two's complement value, one beat per character.
  task automatic expect_decimal_text(input logic [31:0] v);
    logic [32:0] mag;
    logic [3:0]  digit[DigitsN];
    int          n;
    text_beat_t  b;
    mag = v[31] ? 33'h1_0000_0000 - {1'b0, v} : {1'b0, v};
    n = 0;
    do begin
      digit[n] = 4'(mag % 33'd10);
      n++;
      mag = mag / 33'd10;
    end while (mag != 0);
    if (v[31]) begin
      b.ch   = CharMinus;
      b.last = 1'b0;
      text_due.push_back(b);
    end
    for (int k = n - 1; k >= 0; k--) begin
      b.ch   = CharZero + 7'(digit[k]);
      b.last = (k == 0);
      text_due.push_back(b);
    end
  endtask

  task automatic expect_literal_text(input string s);
    text_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.ch   = 7'(s[i]);
      b.last = (i == s.len() - 1);
      text_due.push_back(b);
    end
  endtask

  // Called just after a rising edge. Start stays high into the next value
  // unless a gap is drawn, so it is never lowered and raised in one step.
  task automatic send_value(input logic [31:0] v, input string text, input bit gaps);
    int queued;
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    queued = text_due.size();
    if (text == "") begin
      expect_decimal_text(v);
    end else begin
      expect_literal_text(text);
    end
    values_sent++;
    if (v[31]) negatives_sent++;
    if (text_due.size() - queued == 11) longest_texts++;
    if (gaps && $urandom_range(99) < 9) begin
      start   <= 1'b0;
      value_i <= $urandom;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
    end
  endtask

  // Mostly values of a random digit count, so short texts are as common as
  // long ones; the rest is raw 32-bit noise.
  function automatic logic [31:0] random_value();
    longint lo, hi, m;
    int     d;
    if ($urandom_range(3) == 0) return $urandom;
    d  = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < d; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (d == 1) lo = 0;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    case ($urandom_range(7))
      0:       m = lo;
      1:       m = hi;
      default: m = lo + longint'($urandom_range(32'(hi - lo)));
    endcase
    if ($urandom_range(1) == 1) begin
      m = -m;
      if (d == 10 && $urandom_range(15) == 0) m = m - 1;
    end
    return 32'(m);
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_value(directed[i].value, directed[i].text, 1'b1);
    end
    // A stretch in the middle runs back to back with no gaps at all.
    for (int i = 0; i < RandomValues; i++) begin
      send_value(random_value(), "", !(i >= 150 && i < 260));
    end
    start <= 1'b0;
    while (text_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Converted %0d values (%0d negative, %0d of eleven characters) into %0d beats,",
             values_sent, negatives_sent, longest_texts, beats_seen);
    $display("covering every text length of either sign, with and without sender gaps.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin : check_beat
    text_beat_t want;
    if (rst_ni && valid_o !== 1'b0) begin
      beats_seen++;
      if (text_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual character %h last %b",
                 $time, character_o, last_o);
      end else begin
        want = text_due.pop_front();
        if (character_o !== want.ch) begin
          errors++;
          $display("%0t: character mismatch, expected %h, actual %h",
                   $time, want.ch, character_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last_o);
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither side moved a beat.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/sidec_pkg.sv
rtl/core/sidec_dabble_stage.sv
rtl/core/sidec_serializer.sv
rtl/core/signed_int_to_decimal_ascii.sv
bench/tb_top.sv
